>>> rtl/core/fefc_pkg.sv
// Shared constants, types and register codes for the edge-clamped FIR filter.
// No dependencies; every other file of the block refers to this package.
package fefc_pkg;

  localparam int MAX_TAPS_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int NUM_COEFS       = 7;
  localparam int COEF_W          = 16;
  localparam int TAP_W           = 3;
  localparam int CNT_W           = 3;
  localparam int FRAC_BITS       = 15;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;

  localparam logic [TAP_W-1:0] TAP_RESET = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_RESET [NUM_COEFS] = '{
    16'sd1966, 16'sd1999, 16'sd7930, 16'sd12550, 16'sd7930, 16'sd1999, 16'sd1966
  };

  // One step of the window: whether it yields a result and whether that
  // result closes the vector.
  typedef struct packed {
    logic valid;
    logic last_out;
  } issue_t;

  typedef struct packed {
    logic flushing;
    logic in_vector;
  } win_status_t;

endpackage

>>> rtl/core/fefc_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on fefc_pkg for the default widths.
interface fefc_in_if #(
  parameter int SAMPLE_BITS = fefc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          vector_end;

  modport source (output valid, output sample, output vector_end, input ready);
  modport sink   (input valid, input sample, input vector_end, output ready);
endinterface

interface fefc_out_if #(
  parameter int SAMPLE_BITS = fefc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          final_output;

  modport source (output valid, output filtered, output final_output, input ready);
  modport sink   (input valid, input filtered, input final_output, output ready);
endinterface

interface fefc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fefc_pkg::CFG_IDX_W-1:0]    index;
  logic [fefc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/fir_filter_edge_clamped.sv
// Edge-clamped FIR filter, top level. Depends on fefc_pkg, fefc_ifs, fefc_cfg_regs,
// fefc_window and fefc_mac.
// A result passes through the product, sum and output registers after the item that causes it.
// Throughput: one sample per cycle while the output is not stalled; a vector_end item holds
// the input further while the window shifts in copies of the last sample.
// Reset (synchronous, active low) restores tap count 7, the default coefficients and
// an empty pipeline awaiting the first sample of a vector.
module fir_filter_edge_clamped #(
  parameter int MAX_TAPS    = fefc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fefc_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fefc_in_if.sink     in_ch,
  fefc_out_if.source  out_ch,
  fefc_cfg_if.sink    cfg_ch
);

  logic [fefc_pkg::TAP_W-1:0]    taps;
  fefc_pkg::coef_t               coefs [fefc_pkg::NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] win_nxt [MAX_TAPS];
  fefc_pkg::issue_t              issue;
  fefc_pkg::win_status_t         status;
  logic                          can_take;
  logic                          in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  fefc_cfg_regs #(
    .MAX_TAPS (MAX_TAPS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .taps     (taps),
    .coefs    (coefs)
  );

  fefc_window #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (can_take),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_sample     (in_ch.sample),
    .in_vector_end (in_ch.vector_end),
    .taps          (taps),
    .win_nxt       (win_nxt),
    .issue         (issue),
    .status        (status)
  );

  fefc_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .win          (win_nxt),
    .coefs        (coefs),
    .taps         (taps),
    .issue        (issue),
    .can_take     (can_take),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_filtered (out_ch.filtered),
    .out_final    (out_ch.final_output)
  );

  // A flush only runs inside a vector.
  a_flush_inside: assert property (@(posedge clk) disable iff (!rst_n)
    status.flushing |-> status.in_vector)
    else $error("flush active outside a vector");

  // A single-tap filter finishes a vector on its last sample.
  a_no_flush_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.vector_end && taps == fefc_pkg::TAP_W'(1)) |=> !status.flushing)
    else $error("flush started with a single tap");

  // Wider filters must flush after the last sample.
  a_flush_wide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.vector_end && taps != fefc_pkg::TAP_W'(1)) |=> status.flushing)
    else $error("flush missing after vector end");

endmodule

>>> rtl/core/fefc_cfg_regs.sv
// Configuration registers: tap count and coefficients, plus the effective tap count.
// Depends on fefc_pkg.
module fefc_cfg_regs #(
  parameter int MAX_TAPS = fefc_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [fefc_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [fefc_pkg::CFG_DATA_W-1:0]      wr_data,
  output logic [fefc_pkg::TAP_W-1:0]           taps,
  output fefc_pkg::coef_t                      coefs [fefc_pkg::NUM_COEFS]
);

  localparam int LIM_ODD = (MAX_TAPS % 2 == 0) ? MAX_TAPS - 1 : MAX_TAPS;
  localparam int TAP_LIM = (LIM_ODD > fefc_pkg::NUM_COEFS) ? fefc_pkg::NUM_COEFS : LIM_ODD;
  localparam logic [fefc_pkg::TAP_W-1:0] TAP_LIM_V = fefc_pkg::TAP_W'(TAP_LIM);

  logic [fefc_pkg::TAP_W-1:0]     tap_count_r;
  fefc_pkg::coef_t                coef_r [fefc_pkg::NUM_COEFS];
  logic [fefc_pkg::TAP_W-1:0]     taps_odd;
  logic [fefc_pkg::CFG_IDX_W-1:0] coef_sel;

  assign coef_sel = wr_index - fefc_pkg::REG_COEF_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fefc_pkg::TAP_RESET;
      for (int k = 0; k < fefc_pkg::NUM_COEFS; k++) begin
        coef_r[k] <= fefc_pkg::COEF_RESET[k];
      end
    end else if (wr_en) begin
      unique case (wr_index)
        fefc_pkg::REG_TAP_COUNT: begin
          tap_count_r <= wr_data[fefc_pkg::TAP_W-1:0];
        end
        default: begin
          coef_r[coef_sel] <= fefc_pkg::coef_t'(wr_data);
        end
      endcase
    end
  end

  // Even counts round up to the next odd count; the result never exceeds the window.
  assign taps_odd = tap_count_r | fefc_pkg::TAP_W'(1);
  assign taps     = (taps_odd > TAP_LIM_V) ? TAP_LIM_V : taps_odd;
  assign coefs    = coef_r;

endmodule

>>> rtl/core/fefc_window.sv
// Sample window with edge clamping, vector tracking and the end-of-vector flush.
// Depends on fefc_pkg.
module fefc_window #(
  parameter int MAX_TAPS    = fefc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fefc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_vector_end,
  input  logic [fefc_pkg::TAP_W-1:0]    taps,
  output logic signed [SAMPLE_BITS-1:0] win_nxt [MAX_TAPS],
  output fefc_pkg::issue_t              issue,
  output fefc_pkg::win_status_t         status
);

  localparam int HALF_W = fefc_pkg::TAP_W - 1;
  localparam int CNT_W  = fefc_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] win_r [MAX_TAPS];
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic              inside_r, inside_nxt;
  logic              flush_r, flush_nxt;
  logic [HALF_W-1:0] shift_r, shift_nxt;
  logic [HALF_W-1:0] half;
  logic              in_take;
  logic              flush_step;

  assign half       = taps[fefc_pkg::TAP_W-1:1];
  assign in_ready   = step_en && !flush_r;
  assign in_take    = in_valid && in_ready;
  assign flush_step = flush_r && step_en;

  always_comb begin
    win_nxt    = win_r;
    rc_nxt     = rc_r;
    inside_nxt = inside_r;
    flush_nxt  = flush_r;
    shift_nxt  = shift_r;
    issue      = '0;
    if (in_take) begin
      // The first sample of a vector fills every position, which clamps the left edge.
      if (!inside_r) begin
        for (int d = 0; d < MAX_TAPS; d++) begin
          win_nxt[d] = in_sample;
        end
        rc_nxt = CNT_W'(1);
      end else begin
        for (int d = 1; d < MAX_TAPS; d++) begin
          win_nxt[d] = win_r[d-1];
        end
        win_nxt[0] = in_sample;
        if (rc_r != CNT_MAX) begin
          rc_nxt = rc_r + CNT_W'(1);
        end
      end
      inside_nxt = 1'b1;
      if (!in_vector_end) begin
        issue.valid = rc_nxt > CNT_W'(half);
      end else begin
        issue.valid    = ({1'b0, rc_nxt} - (CNT_W+1)'(1)) >= (CNT_W+1)'(half);
        issue.last_out = (half == '0);
        if (half == '0) begin
          rc_nxt     = '0;
          inside_nxt = 1'b0;
        end else begin
          flush_nxt = 1'b1;
          shift_nxt = HALF_W'(1);
        end
      end
    end else if (flush_step) begin
      // Copies of the last sample clamp the right edge.
      for (int d = 1; d < MAX_TAPS; d++) begin
        win_nxt[d] = win_r[d-1];
      end
      win_nxt[0]     = win_r[0];
      issue.valid    = ({1'b0, rc_r} - (CNT_W+1)'(1) + (CNT_W+1)'(shift_r))
                       >= (CNT_W+1)'(half);
      issue.last_out = (shift_r == half);
      if (shift_r == half) begin
        flush_nxt  = 1'b0;
        rc_nxt     = '0;
        inside_nxt = 1'b0;
      end else begin
        shift_nxt = shift_r + HALF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r     <= '0;
      inside_r <= 1'b0;
      flush_r  <= 1'b0;
      shift_r  <= '0;
    end else begin
      rc_r     <= rc_nxt;
      inside_r <= inside_nxt;
      flush_r  <= flush_nxt;
      shift_r  <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign status.flushing  = flush_r;
  assign status.in_vector = inside_r;

endmodule

>>> rtl/core/fefc_mac.sv
// Three-stage multiply, sum and round/saturate pipeline with the result register.
// Depends on fefc_pkg.
module fefc_mac #(
  parameter int MAX_TAPS    = fefc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fefc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS],
  input  fefc_pkg::coef_t               coefs [fefc_pkg::NUM_COEFS],
  input  logic [fefc_pkg::TAP_W-1:0]    taps,
  input  fefc_pkg::issue_t              issue,
  output logic                          can_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_filtered,
  output logic                          out_final
);

  localparam int NC        = fefc_pkg::NUM_COEFS;
  localparam int TAP_W     = fefc_pkg::TAP_W;
  localparam int FRAC      = fefc_pkg::FRAC_BITS;
  localparam int PROD_W    = SAMPLE_BITS + fefc_pkg::COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(NC) + 1;
  localparam int Q_W       = ACC_W - FRAC;
  localparam int WIN_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [Q_W-1:0] Q_HI =
    {{(Q_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_LO = ~Q_HI;

  logic signed [PROD_W-1:0]      prod_nxt [NC];
  logic signed [PROD_W-1:0]      prod_r [NC];
  logic [WIN_IDX_W-1:0]          tap_sel [NC];
  logic                          v1_r, last1_r;
  logic signed [ACC_W-1:0]       acc_nxt, acc_r;
  logic                          v2_r, last2_r;
  logic signed [ACC_W-1:0]       rounded;
  logic signed [Q_W-1:0]         q;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_valid_r, out_final_r;
  logic signed [SAMPLE_BITS-1:0] out_filtered_r;
  logic                          load1, load2, load3;

  assign load3    = !out_valid_r || out_ready;
  assign load2    = !v2_r || load3;
  assign load1    = !v1_r || load2;
  assign can_take = load1;

  // Coefficient k weights the sample that is taps-1-k positions old.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      tap_sel[k] = WIN_IDX_W'(taps - TAP_W'(k) - TAP_W'(1));
      if (TAP_W'(k) < taps) begin
        prod_nxt[k] = PROD_W'(coefs[k]) * PROD_W'(win[tap_sel[k]]);
      end else begin
        prod_nxt[k] = '0;
      end
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int k = 0; k < NC; k++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[k]);
    end
  end

  // Halves round up; the arithmetic shift gives the floor.
  assign rounded = acc_r + ROUND_BIAS;
  assign q       = Q_W'(rounded >>> FRAC);

  always_comb begin
    if (q > Q_HI) begin
      sat = Q_HI[SAMPLE_BITS-1:0];
    end else if (q < Q_LO) begin
      sat = Q_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load1) begin
        v1_r <= issue.valid;
      end
      if (load2) begin
        v2_r <= v1_r;
      end
      if (load3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && issue.valid) begin
      prod_r  <= prod_nxt;
      last1_r <= issue.last_out;
    end
    if (load2 && v1_r) begin
      acc_r   <= acc_nxt;
      last2_r <= last1_r;
    end
    if (load3 && v2_r) begin
      out_filtered_r <= sat;
      out_final_r    <= last2_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_final    = out_final_r;

endmodule
